### hw/rtl/radio_link_mode_manager_assert.svh
// assertion macros for the radio link mode manager checker
`ifndef RADIO_LINK_MODE_MANAGER_ASSERT_SVH
`define RADIO_LINK_MODE_MANAGER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define RLMM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rlmm assertion failed");

// next-cycle implication, disabled while reset is held
`define RLMM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rlmm assertion failed");

`endif

### hw/rtl/rlmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmm_pkg
// shared types, codes and widths of the radio link mode manager
// ----------------------------------------------------------------------------
package rlmm_pkg;

    localparam int TICKS_W     = 16;
    localparam int PERIOD_W    = 8;
    localparam int LEN_W       = 8;
    localparam int STATUS_W    = 5;
    localparam int FUNC_W      = 3;
    localparam int EV_W        = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MAX_PASSES  = 3;
    localparam int PASS_CNT_W  = 2;
    localparam int DIV_STEPS   = TICKS_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [TICKS_W-1:0] TICKS_MAX = 16'hFFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HC_PERIOD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_READY_CODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_RDONE = 3'd4;

    // register reset values
    localparam logic [LEN_W-1:0]    RST_MAX_PAYLOAD = 8'd61;
    localparam logic [PERIOD_W-1:0] RST_HC_PERIOD   = 8'd10;
    localparam logic [TICKS_W-1:0]  RST_TIMEOUT     = 16'd10;
    localparam logic [STATUS_W-1:0] RST_READY_CODE  = 5'd13;
    localparam logic                RST_NOTIFY      = 1'b1;

    // event codes; entry is internal only
    localparam logic [EV_W-1:0] EV_TICK   = 4'd0;
    localparam logic [EV_W-1:0] EV_RESET  = 4'd1;
    localparam logic [EV_W-1:0] EV_NOTIFY = 4'd2;
    localparam logic [EV_W-1:0] EV_SEND   = 4'd3;
    localparam logic [EV_W-1:0] EV_SDONE  = 4'd4;
    localparam logic [EV_W-1:0] EV_RXDONE = 4'd5;
    localparam logic [EV_W-1:0] EV_ENTRY  = 4'd8;

    localparam logic [1:0] IRQ_NONE    = 2'd0;
    localparam logic [1:0] IRQ_ENABLE  = 2'd1;
    localparam logic [1:0] IRQ_DISABLE = 2'd2;

    localparam logic [1:0] TXR_NONE = 2'd0;
    localparam logic [1:0] TXR_FAIL = 2'd1;
    localparam logic [1:0] TXR_OK   = 2'd2;

    typedef enum logic [2:0] {
        MODE_INIT  = 3'd0,
        MODE_RESET = 3'd1,
        MODE_IDLE  = 3'd2,
        MODE_RX    = 3'd3,
        MODE_TX    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_MOD,
        SEQ_PASS
    } seq_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } mod_stat_t;

    typedef struct packed {
        mode_t           mode;
        logic [EV_W-1:0] ev;
        logic            ready;
        logic            start_ok;
        logic            res_ok;
        logic            pending;
        logic            notify;
        logic            hc_zero;
    } pass_in_t;

    typedef struct packed {
        mode_t      nx;
        logic       pending_next;
        logic       init_cmd;
        logic       set_rx;
        logic       reset_done;
        logic [1:0] irq;
        logic       start_rx;
        logic       deliver;
        logic       start_tx;
        logic [1:0] txrep;
    } pass_out_t;

endpackage

### hw/rtl/rlmm_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmm_mod_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module rlmm_mod_unit
    import rlmm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [TICKS_W-1:0]  dividend,
    input  logic [PERIOD_W-1:0] divisor,
    output mod_stat_t           stat
);

    logic [TICKS_W-1:0]   dvd_reg, dvd_next;
    logic [PERIOD_W-1:0]  dvs_reg, dvs_next;
    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [PERIOD_W:0]    trial;
    logic [PERIOD_W:0]    diff;

    assign trial = {rem_reg, dvd_reg[TICKS_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[TICKS_W-2:0], 1'b0};
            // partial remainder always stays below the divisor
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[PERIOD_W-1:0];
            end else begin
                rem_next = trial[PERIOD_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

### hw/rtl/rlmm_pass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmm_pass
// mode logic of one pass: next mode, pending flag and commands
// ----------------------------------------------------------------------------
module rlmm_pass
    import rlmm_pkg::*;
(
    input  pass_in_t  pin,
    output pass_out_t pout
);

    always_comb begin
        pout              = '0;
        pout.nx           = pin.mode;
        pout.pending_next = pin.pending;
        pout.irq          = IRQ_NONE;
        pout.txrep        = TXR_NONE;
        unique case (pin.mode)
            MODE_RESET: begin
                if (pin.ev == EV_ENTRY) begin
                    pout.irq          = IRQ_DISABLE;
                    pout.init_cmd     = 1'b1;
                    pout.pending_next = 1'b0;
                end else if (pin.ev == EV_TICK) begin
                    pout.set_rx = 1'b1;
                    if (pin.ready) begin
                        pout.irq        = IRQ_ENABLE;
                        pout.reset_done = pin.notify;
                        pout.nx         = MODE_IDLE;
                    end
                end
            end
            MODE_IDLE: begin
                if (pin.ev == EV_ENTRY) begin
                    pout.irq = IRQ_ENABLE;
                end else if (pin.ev == EV_NOTIFY) begin
                    pout.nx = MODE_RX;
                end else if (pin.ev == EV_SEND) begin
                    pout.nx = MODE_TX;
                end else if (pin.ev == EV_TICK) begin
                    // health check: count at a period multiple and radio not ready
                    if (pin.hc_zero && !pin.ready) begin
                        pout.nx = MODE_RESET;
                    end
                end
            end
            MODE_RX: begin
                if (pin.ev == EV_ENTRY) begin
                    pout.start_rx = 1'b1;
                    pout.deliver  = 1'b1;
                    if (!pin.start_ok) begin
                        pout.nx = MODE_IDLE;
                    end
                end else if (pin.ev == EV_RXDONE) begin
                    pout.deliver = 1'b1;
                    pout.nx      = MODE_IDLE;
                end
            end
            MODE_TX: begin
                if (pin.ev == EV_ENTRY) begin
                    pout.irq = IRQ_DISABLE;
                    if (!pin.pending) begin
                        pout.nx = MODE_RESET;
                    end else begin
                        pout.start_tx = 1'b1;
                        if (!pin.start_ok) begin
                            pout.txrep        = TXR_FAIL;
                            pout.pending_next = 1'b0;
                            pout.nx           = MODE_IDLE;
                        end
                    end
                end else if (pin.ev == EV_SDONE) begin
                    if (pin.pending) begin
                        pout.txrep = pin.res_ok ? TXR_OK : TXR_FAIL;
                    end
                    pout.pending_next = 1'b0;
                    pout.nx           = MODE_IDLE;
                end
            end
            default: begin
                // init mode has no mode logic
            end
        endcase
    end

endmodule

### hw/rtl/radio_link_mode_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_link_mode_manager
// event-driven mode manager for a packet radio link
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one event per beat: the event code in s_tuser and the
//   sampled radio status, send length and driver answers in s_tdata.
//   m_ channel returns one to three result beats per event, one for each
//   chained pass of entry actions; m_tlast marks the final beat of an event.
//   cfg_ channel writes the five configuration registers, one per beat; it is
//   always ready and is meant to be written only while no event is in flight.
// sequencing:
//   an event is taken into the held event registers; the sequencer state
//   is registered, and each pass then loads the output register.
//   a tick in idle mode first runs the health-check remainder through the
//   bit-serial remainder unit, 16 steps and a handoff through its done
//   register ahead of the passes. s_tready stays low while an event is
//   worked and rises once its last result is in the output register.
// reset: mode init, time count zero, no pending packet, registers to their
//   defaults, output channel empty.
// stall: with m_tready low the output register holds its beat and the
//   sequencer waits before the next pass; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module radio_link_mode_manager
    import rlmm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // event beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] payload_length, [12:8] radio_status, [13] driver_start_ok,
    // [14] send_result_ok, [15] zero
    input  logic [15:0]           s_tdata,
    // [2:0] func
    input  logic [2:0]            s_tuser,
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] new_state, [3] send_accepted, [4] radio_init_cmd, [5] set_rx_cmd,
    // [6] reset_done, [8:7] irq_action, [9] start_rx, [10] deliver_rx,
    // [11] start_tx, [13:12] tx_report, [15:14] zero
    output logic [15:0]           m_tdata,
    output logic                  m_tlast,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [LEN_W-1:0]    max_len_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [TICKS_W-1:0]  timeout_reg;
    logic [STATUS_W-1:0] ready_code_reg;
    logic                notify_reg;

    // block state
    seq_t                 seq_reg, seq_next;
    mode_t                mode_reg, mode_next;
    logic [TICKS_W-1:0]   ticks_reg, ticks_next;
    logic                 pending_reg, pending_next;

    // event held while its passes run
    logic [EV_W-1:0]      ev_reg, ev_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 start_ok_reg, start_ok_next;
    logic                 res_ok_reg, res_ok_next;
    logic                 accepted_reg, accepted_next;
    logic                 refused_reg, refused_next;
    logic                 hc_zero_reg, hc_zero_next;
    logic [PASS_CNT_W-1:0] pass_cnt_reg, pass_cnt_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [15:0]          m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;

    // input fields
    logic [FUNC_W-1:0]    in_func;
    logic [LEN_W-1:0]     in_len;
    logic [STATUS_W-1:0]  in_status;
    logic                 in_start_ok;
    logic                 in_res_ok;

    logic                 in_beat;
    logic                 out_load;
    logic                 send_ok;
    logic                 timed_out;
    logic [TICKS_W-1:0]   ticks_inc;
    logic                 mod_start;
    mod_stat_t            mod_stat;
    pass_in_t             pin;
    pass_out_t            pout;
    logic                 pass_last;

    assign in_func     = s_tuser;
    assign in_len      = s_tdata[7:0];
    assign in_status   = s_tdata[12:8];
    assign in_start_ok = s_tdata[13];
    assign in_res_ok   = s_tdata[14];

    assign s_tready  = (seq_reg == SEQ_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign ticks_inc = (ticks_reg != TICKS_MAX) ? ticks_reg + 1'b1 : ticks_reg;
    assign send_ok   = !pending_reg && (in_len <= max_len_reg) && (mode_reg == MODE_IDLE);
    assign timed_out = (ticks_reg > timeout_reg) && (mode_reg != MODE_IDLE);

    // health-check remainder only matters for a tick in idle mode
    assign mod_start = in_beat && ({1'b0, in_func} == EV_TICK) &&
                       (mode_reg == MODE_IDLE) && (period_reg != '0);

    rlmm_mod_unit u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (ticks_inc),
        .divisor  (period_reg),
        .stat     (mod_stat)
    );

    assign pin.mode     = mode_reg;
    assign pin.ev       = ev_reg;
    assign pin.ready    = (status_reg == ready_code_reg);
    assign pin.start_ok = start_ok_reg;
    assign pin.res_ok   = res_ok_reg;
    assign pin.pending  = pending_reg;
    assign pin.notify   = notify_reg;
    assign pin.hc_zero  = hc_zero_reg;

    rlmm_pass u_pass (
        .pin  (pin),
        .pout (pout)
    );

    assign out_load  = (seq_reg == SEQ_PASS) && (!m_valid_reg || m_tready);
    assign pass_last = refused_reg || (pout.nx == mode_reg) ||
                       (pass_cnt_reg == PASS_CNT_W'(MAX_PASSES - 1));

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg    <= RST_MAX_PAYLOAD;
            period_reg     <= RST_HC_PERIOD;
            timeout_reg    <= RST_TIMEOUT;
            ready_code_reg <= RST_READY_CODE;
            notify_reg     <= RST_NOTIFY;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MAX_PAYLOAD:  max_len_reg    <= cfg_data[LEN_W-1:0];
                REG_HC_PERIOD:    period_reg     <= cfg_data[PERIOD_W-1:0];
                REG_TIMEOUT:      timeout_reg    <= cfg_data[TICKS_W-1:0];
                REG_READY_CODE:   ready_code_reg <= cfg_data[STATUS_W-1:0];
                REG_NOTIFY_RDONE: notify_reg     <= cfg_data[0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // sequencer: next state, block state and output register
    always_comb begin
        seq_next      = seq_reg;
        mode_next     = mode_reg;
        ticks_next    = ticks_reg;
        pending_next  = pending_reg;
        ev_next       = ev_reg;
        status_next   = status_reg;
        start_ok_next = start_ok_reg;
        res_ok_next   = res_ok_reg;
        accepted_next = accepted_reg;
        refused_next  = refused_reg;
        hc_zero_next  = hc_zero_reg;
        pass_cnt_next = pass_cnt_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (seq_reg)
            SEQ_IDLE: begin
                if (in_beat) begin
                    status_next   = in_status;
                    start_ok_next = in_start_ok;
                    res_ok_next   = in_res_ok;
                    accepted_next = 1'b0;
                    refused_next  = 1'b0;
                    hc_zero_next  = 1'b0;
                    pass_cnt_next = '0;
                    ev_next       = {1'b0, in_func};
                    seq_next      = mod_start ? SEQ_MOD : SEQ_PASS;
                    if ({1'b0, in_func} == EV_SEND && !send_ok) begin
                        // refused send: one result with the current mode only
                        refused_next = 1'b1;
                    end else begin
                        if ({1'b0, in_func} == EV_SEND) begin
                            accepted_next = 1'b1;
                            pending_next  = 1'b1;
                        end
                        if ({1'b0, in_func} == EV_TICK) begin
                            ticks_next = ticks_inc;
                        end else if ({1'b0, in_func} == EV_RESET || timed_out) begin
                            // forced reset keeps the count
                            ev_next   = EV_ENTRY;
                            mode_next = MODE_RESET;
                        end
                    end
                end
            end
            SEQ_MOD: begin
                if (mod_stat.done) begin
                    hc_zero_next = mod_stat.rem_zero;
                    seq_next     = SEQ_PASS;
                end
            end
            SEQ_PASS: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_last_next  = pass_last;
                    if (refused_reg) begin
                        m_data_next = {13'd0, mode_reg};
                    end else begin
                        m_data_next = {2'b00, pout.txrep, pout.start_tx, pout.deliver,
                                       pout.start_rx, pout.irq, pout.reset_done,
                                       pout.set_rx, pout.init_cmd,
                                       accepted_reg && (pass_cnt_reg == '0), pout.nx};
                        pending_next = pout.pending_next;
                        if (pout.nx != mode_reg) begin
                            mode_next  = pout.nx;
                            ticks_next = '0;
                            ev_next    = EV_ENTRY;
                        end
                    end
                    pass_cnt_next = pass_cnt_reg + 1'b1;
                    if (pass_last) begin
                        seq_next = SEQ_IDLE;
                    end
                end
            end
            default: begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg     <= SEQ_IDLE;
            mode_reg    <= MODE_INIT;
            ticks_reg   <= '0;
            pending_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            seq_reg     <= seq_next;
            mode_reg    <= mode_next;
            ticks_reg   <= ticks_next;
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_reg       <= ev_next;
        status_reg   <= status_next;
        start_ok_reg <= start_ok_next;
        res_ok_reg   <= res_ok_next;
        accepted_reg <= accepted_next;
        refused_reg  <= refused_next;
        hc_zero_reg  <= hc_zero_next;
        pass_cnt_reg <= pass_cnt_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

### hw/rtl/rlmm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmm_checker
// port-level checks of the radio link mode manager
// ----------------------------------------------------------------------------
`include "radio_link_mode_manager_assert.svh"

module rlmm_checker
    import rlmm_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [15:0]           m_tdata,
    input logic                  m_tlast
);

    // stalled result beat holds
    `RLMM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // s_tready is low in the cycle after an event is taken
    `RLMM_ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_tvalid && s_tready,
        !s_tready)

    // an accepted send always moves the link into transmit mode
    `RLMM_ASSERT_NOW(a_accept_to_tx, aclk, aresetn, m_tvalid && m_tdata[3],
        m_tdata[2:0] == MODE_TX)

    // a radio reinit only comes with reset entry and interrupts disabled
    `RLMM_ASSERT_NOW(a_init_in_reset, aclk, aresetn, m_tvalid && m_tdata[4],
        (m_tdata[2:0] == MODE_RESET) && (m_tdata[8:7] == IRQ_DISABLE) && m_tlast)

endmodule

bind radio_link_mode_manager rlmm_checker u_rlmm_checker (.*);
